// ===== design/hba_pkg.sv =====
// Package for the heap block allocator: payload structs, codes, states.
// No dependencies.
package hba_pkg;
  localparam int MaxBlocksDef = 64;
  localparam int AddrBitsDef  = 20;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_ZERO = 3'd1, ST_ARENA = 3'd2, ST_BADREL = 3'd3, ST_FULL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0, POL_BEST = 2'd1, POL_WORST = 2'd2, POL_NEXT = 2'd3
  } policy_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_LIMIT  = 2'd1;
  localparam logic [1:0] REG_HDR    = 2'd2;

  typedef struct packed {
    logic        op;
    logic [19:0] request_size;
    logic [19:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] data_address;
    logic        was_reused;
    logic        was_split;
    logic        heap_grew;
    logic [5:0]  merge_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SLOT, S_SRCH_RD, S_SRCH, S_ALLOC_RD, S_ALLOC, S_GROW,
    S_REL_RD, S_REL, S_MRG_RD, S_MRG, S_DONE
  } state_t;
endpackage

// ===== design/heap_block_allocator_unit.sv =====
// Heap block allocator: one request in, one result out, valid/ready on both sides.
// Configuration by a plain write port (0 fit policy, 1 heap limit, 2 header bytes).
// Each request walks the address-ordered block table one entry at a time,
// using a single table read port and one shared add/compare datapath.
// An allocate scans the table once for a free slot and once along the list
// (a next-fit wrap included), then updates the table. A release walks the
// list to find the block and walks it again merging adjacent free pairs,
// with each entry read at most twice in the merge walk.
// A zero-size request, or a release on an empty list, goes straight to the
// done state.
// in_ready is high only while no request is in work and no result is held.
// A result sits in an output register until out_ready takes it; the block
// waits meanwhile and accepts the next item the cycle after.
// Synchronous active-low reset empties the list, clears all entry valid bits,
// zeroes the heap top and restores register defaults; the table contents
// themselves are not cleared, no clearing pass is needed.
// The table is held as plain arrays written and read in clocked blocks.
module heap_block_allocator_unit
  import hba_pkg::*;
#(
  parameter int MAX_BLOCKS = MaxBlocksDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [19:0] cfg_data
);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int PW = IW + 1;
  localparam logic [PW-1:0] NONE = PW'(MAX_BLOCKS);
  localparam logic [43:0] AMASK = 44'((64'd1 << AddrBitsDef) - 64'd1);

  // Table storage.
  logic [19:0] start_mem [MAX_BLOCKS];
  logic [19:0] size_mem  [MAX_BLOCKS];
  logic        free_mem  [MAX_BLOCKS];
  logic [IW-1:0] link_mem [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] valid_r;

  logic [1:0]  policy_r;
  logic [19:0] limit_r;
  logic [6:0]  hdr_r;
  logic [PW-1:0] head_r, tail_r, nfp_r;
  logic [19:0] top_r;

  state_t state_r, state_nxt;
  in_item_t req_r;
  out_item_t res_r;
  logic out_valid_r;

  logic [PW-1:0] cur_r, found_r, spare_r, nf_start_r, pend_r;
  logic [PW:0]   cnt_r;
  logic [20:0]   keep_r;
  logic [20:0]   need_r;
  logic [5:0]    merges_r;

  // One registered read port on the table.
  logic [IW-1:0] rd_addr;
  logic [19:0]   rd_start, rd_size;
  logic          rd_free;
  logic [IW-1:0] rd_link;
  logic [PW-1:0] rd_idx_r;

  always_ff @(posedge clk) begin
    rd_start <= start_mem[rd_addr];
    rd_size  <= size_mem[rd_addr];
    rd_free  <= free_mem[rd_addr];
    rd_link  <= link_mem[rd_addr];
    rd_idx_r <= {1'b0, rd_addr};
  end

  // Follow the list from the entry that was just read.
  logic [PW-1:0] fol;
  always_comb begin
    if (rd_idx_r == tail_r) fol = NONE;
    else fol = {1'b0, rd_link};
  end

  // Shared arithmetic.
  logic [20:0] have;
  logic        fit;
  logic [20:0] rem;
  logic [43:0] daddr;
  assign have  = {1'b0, rd_size};
  assign fit   = rd_free && (have >= need_r);
  assign rem   = have - need_r;
  assign daddr = (44'(rd_start) + 44'(hdr_r)) & AMASK;

  logic [43:0] newtop;
  logic [21:0] splitrem;
  assign newtop   = 44'(top_r) + 44'(hdr_r) + 44'(need_r);
  assign splitrem = 22'(have) - 22'(need_r) - 22'(hdr_r);

  // Walk decisions shared by the sequencer and the datapath.
  logic          last;
  logic          nf_use;
  logic          srch_take, srch_stop;
  logic [PW-1:0] srch_nx;
  logic          rel_hit;
  logic          mrg_end;
  out_item_t     res_first;

  assign last    = (cnt_r == (PW+1)'(MAX_BLOCKS - 1));
  assign nf_use  = (policy_r == POL_NEXT) && (nfp_r != NONE);
  assign rel_hit = !rd_free && (daddr[19:0] == req_r.release_address);

  always_comb begin
    srch_take = 1'b0;
    srch_stop = 1'b0;
    srch_nx = fol;
    if (fit) begin
      if (policy_r == POL_BEST || policy_r == POL_WORST) begin
        if (found_r == NONE || (policy_r == POL_BEST ? rem < keep_r : rem > keep_r))
          srch_take = 1'b1;
      end else begin
        srch_take = 1'b1;
        srch_stop = 1'b1;
      end
    end
    // A next-fit scan wraps from the tail to the head and ends at its start.
    if (nf_start_r != NONE) begin
      if (srch_nx == NONE) srch_nx = head_r;
      if (srch_nx == nf_start_r || srch_nx == NONE) srch_stop = 1'b1;
    end else if (srch_nx == NONE) srch_stop = 1'b1;
    if (last) srch_stop = 1'b1;
  end

  always_comb begin
    if (pend_r != NONE) mrg_end = last || (rd_free && fol == NONE);
    else mrg_end = !(rd_free && fol != NONE) && (fol == NONE || last);
  end

  always_comb begin
    res_first = '0;
    if (in_item.op == OP_FREE) begin
      if (head_r == NONE) res_first.status = ST_BADREL;
    end else if (in_item.request_size == '0) begin
      res_first.status = ST_ZERO;
    end
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE) && !out_valid_r;
    out_valid = out_valid_r;
    out_item  = res_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_item.op == OP_FREE) state_nxt = (head_r == NONE) ? S_DONE : S_REL_RD;
          else if (in_item.request_size == '0) state_nxt = S_DONE;
          else state_nxt = S_SLOT;
        end
      end
      S_SLOT: begin
        if (last) state_nxt = (head_r == NONE && !nf_use) ? S_GROW : S_SRCH_RD;
      end
      S_SRCH_RD: state_nxt = S_SRCH;
      S_SRCH: begin
        if (!srch_stop) state_nxt = S_SRCH_RD;
        else if (srch_take || found_r != NONE) state_nxt = S_ALLOC_RD;
        else state_nxt = S_GROW;
      end
      S_ALLOC_RD: state_nxt = S_ALLOC;
      S_ALLOC:    state_nxt = S_DONE;
      S_GROW:     state_nxt = S_DONE;
      S_REL_RD:   state_nxt = S_REL;
      S_REL: begin
        if (rel_hit) state_nxt = S_MRG_RD;
        else if (fol == NONE || last) state_nxt = S_DONE;
        else state_nxt = S_REL_RD;
      end
      S_MRG_RD: state_nxt = S_MRG;
      S_MRG:    state_nxt = mrg_end ? S_DONE : S_MRG_RD;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr = cur_r[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      policy_r    <= POL_FIRST;
      limit_r     <= 20'hFFFFF;
      hdr_r       <= 7'd24;
      head_r      <= NONE;
      tail_r      <= NONE;
      nfp_r       <= NONE;
      top_r       <= '0;
      cur_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POLICY: policy_r <= cfg_data[1:0];
          REG_LIMIT:  limit_r  <= cfg_data;
          REG_HDR:    hdr_r    <= cfg_data[6:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req_r    <= in_item;
            res_r    <= res_first;
            need_r   <= ({1'b0, in_item.request_size} + 21'd3) & ~21'd3;
            merges_r <= '0;
            cnt_r    <= '0;
            cur_r    <= (in_item.op == OP_FREE) ? head_r : '0;
            spare_r  <= NONE;
            found_r  <= NONE;
          end
        end
        // Find the lowest unused table entry, one entry a cycle.
        S_SLOT: begin
          if (spare_r == NONE && !valid_r[cnt_r[IW-1:0]]) spare_r <= cnt_r[PW-1:0];
          if (last) begin
            if (nf_use) begin
              cur_r <= nfp_r; nf_start_r <= nfp_r;
            end else begin
              cur_r <= head_r; nf_start_r <= NONE;
            end
            cnt_r <= '0;
          end else cnt_r <= cnt_r + 1'b1;
        end
        S_SRCH_RD: ;
        S_SRCH: begin
          if (srch_take) begin found_r <= rd_idx_r; keep_r <= rem; end
          cnt_r <= cnt_r + 1'b1;
          if (srch_stop) begin
            cur_r <= srch_take ? rd_idx_r : found_r;
            if (policy_r == POL_NEXT && srch_take) nfp_r <= rd_idx_r;
          end else cur_r <= srch_nx;
        end
        S_ALLOC_RD: ;
        S_ALLOC: begin
          res_r.was_reused   <= 1'b1;
          res_r.data_address <= daddr[19:0];
          free_mem[rd_idx_r[IW-1:0]] <= 1'b0;
          if (have > need_r && 22'(rem) > 22'(hdr_r) + 22'd4 && spare_r != NONE) begin
            start_mem[spare_r[IW-1:0]] <= 20'((44'(rd_start) + 44'(need_r) + 44'(hdr_r)) & AMASK);
            size_mem[spare_r[IW-1:0]]  <= 20'(44'(splitrem) & AMASK);
            free_mem[spare_r[IW-1:0]]  <= 1'b1;
            link_mem[spare_r[IW-1:0]]  <= (fol == NONE) ? '0 : fol[IW-1:0];
            valid_r[spare_r[IW-1:0]]   <= 1'b1;
            if (rd_idx_r == tail_r) tail_r <= spare_r;
            link_mem[rd_idx_r[IW-1:0]] <= spare_r[IW-1:0];
            size_mem[rd_idx_r[IW-1:0]] <= need_r[19:0];
            res_r.was_split <= 1'b1;
          end
        end
        S_GROW: begin
          if (spare_r == NONE) res_r.status <= ST_FULL;
          else if (newtop > 44'(limit_r) || newtop > AMASK) res_r.status <= ST_ARENA;
          else begin
            start_mem[spare_r[IW-1:0]] <= top_r;
            size_mem[spare_r[IW-1:0]]  <= need_r[19:0];
            free_mem[spare_r[IW-1:0]]  <= 1'b0;
            link_mem[spare_r[IW-1:0]]  <= '0;
            valid_r[spare_r[IW-1:0]]   <= 1'b1;
            if (head_r == NONE) head_r <= spare_r;
            else link_mem[tail_r[IW-1:0]] <= spare_r[IW-1:0];
            tail_r <= spare_r;
            res_r.data_address <= 20'((44'(top_r) + 44'(hdr_r)) & AMASK);
            top_r <= newtop[19:0];
            res_r.heap_grew <= 1'b1;
          end
        end
        S_REL_RD: ;
        S_REL: begin
          if (rel_hit) begin
            free_mem[rd_idx_r[IW-1:0]] <= 1'b1;
            cur_r <= head_r;
            cnt_r <= '0;
            pend_r <= NONE;
          end else if (fol == NONE || last) begin
            res_r.status <= ST_BADREL;
          end else begin
            cur_r <= fol;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        // Merge walk: pend_r holds a free block whose successor is now read.
        S_MRG_RD: ;
        S_MRG: begin
          nfp_r <= NONE;
          if (pend_r != NONE) begin
            pend_r <= NONE;
            cnt_r <= cnt_r + 1'b1;
            if (rd_free) begin
              size_mem[pend_r[IW-1:0]] <= 20'((44'(keep_r[19:0]) + 44'(rd_size)
                                               + 44'(hdr_r)) & AMASK);
              if (rd_idx_r == tail_r) tail_r <= pend_r;
              else link_mem[pend_r[IW-1:0]] <= rd_link;
              valid_r[rd_idx_r[IW-1:0]] <= 1'b0;
              if (merges_r != 6'd63) merges_r <= merges_r + 1'b1;
              cur_r <= fol;
            end else begin
              // Not merged: this successor is the next walk step, read it again.
              cur_r <= rd_idx_r;
            end
          end else if (rd_free && fol != NONE) begin
            pend_r <= rd_idx_r;
            keep_r <= {1'b0, rd_size};
            cur_r <= fol;
          end else begin
            cnt_r <= cnt_r + 1'b1;
            cur_r <= fol;
          end
        end
        S_DONE: begin
          if (req_r.op == OP_FREE) res_r.merge_count <= merges_r;
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("result not presented");
  a_free_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.merge_count != 6'd0) |-> (out_item.data_address == 20'd0))
    else $error("release carried an address");
endmodule

// ===== test/heap_block_allocator_unit_tb.sv =====
// Testbench for heap_block_allocator_unit: directed and random allocate/release items,
// checked against an in-bench allocator predictor. Depends on hba_pkg and the RTL only.
module heap_block_allocator_unit_tb;
  import hba_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = 64;
  localparam int NONE = NB;
  localparam logic [19:0] AMASK = 20'hFFFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_POLICY;
  logic [19:0] cfg_data = '0;

  heap_block_allocator_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predicted allocator state.
  logic [19:0] blk_start[NB];
  logic [19:0] blk_size[NB];
  bit blk_free[NB];
  logic [5:0] blk_link[NB];
  bit blk_used[NB];
  int head = NONE, tail = NONE, nf_pos = NONE;
  longint heap_top = 0;
  policy_t policy = POL_FIRST;
  longint limit = 1048575;
  longint hdr = 24;

  in_item_t pending_reqs[$];
  out_item_t expected_results[$];
  int fails = 0;
  int idle_mode = 0;
  int hold_asks = 0;

  function automatic int link_of(int i);
    if (i >= NONE || i == tail) return NONE;
    return int'(blk_link[i]);
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < NB; i++) if (!blk_used[i]) return i;
    return NONE;
  endfunction

  function automatic bit can_hold(int i, longint need);
    return i < NONE && blk_free[i] && longint'(blk_size[i]) >= need;
  endfunction

  function automatic int find_block(longint need);
    int cur;
    int found;
    longint keep;
    found = NONE;
    keep = 0;
    if (policy == POL_BEST || policy == POL_WORST) begin
      cur = head;
      for (int n = 0; cur < NONE && n < NB; n++) begin
        if (can_hold(cur, need)) begin
          if (found == NONE || (policy == POL_BEST ? (blk_size[cur] - need < keep)
                                                   : (blk_size[cur] - need > keep))) begin
            found = cur;
            keep = blk_size[cur] - need;
          end
        end
        cur = link_of(cur);
      end
      return found;
    end
    if (policy == POL_NEXT && nf_pos < NONE) begin
      // Wrap from the tail back to the head, stopping short of the start point.
      cur = nf_pos;
      for (int n = 0; n < NB; n++) begin
        if (can_hold(cur, need)) begin
          nf_pos = cur;
          return cur;
        end
        cur = link_of(cur);
        if (cur == NONE) cur = head;
        if (cur == nf_pos || cur == NONE) break;
      end
      return NONE;
    end
    cur = head;
    for (int n = 0; cur < NONE && n < NB; n++) begin
      if (can_hold(cur, need)) begin
        if (policy == POL_NEXT) nf_pos = cur;
        return cur;
      end
      cur = link_of(cur);
    end
    return NONE;
  endfunction

  function automatic out_item_t predict_alloc(logic [19:0] req);
    out_item_t r;
    longint need, have, newtop;
    int pick, s;
    r = '0;
    need = ((longint'(req) + 3) >> 2) << 2;
    if (need == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    pick = find_block(need);
    if (pick < NONE) begin
      have = blk_size[pick];
      if (have > need && have - need > hdr + 4) begin
        s = free_slot();
        if (s < NONE) begin
          blk_start[s] = 20'((longint'(blk_start[pick]) + need + hdr) & AMASK);
          blk_size[s] = 20'((have - need - hdr) & AMASK);
          blk_free[s] = 1;
          blk_link[s] = 6'(link_of(pick) < NONE ? link_of(pick) : 0);
          blk_used[s] = 1;
          if (pick == tail) tail = s;
          blk_link[pick] = 6'(s);
          blk_size[pick] = 20'(need);
          r.was_split = 1'b1;
        end
      end
      blk_free[pick] = 0;
      r.data_address = 20'((longint'(blk_start[pick]) + hdr) & AMASK);
      r.was_reused = 1'b1;
      return r;
    end
    s = free_slot();
    if (s >= NONE) begin
      r.status = ST_FULL;
      return r;
    end
    newtop = heap_top + hdr + need;
    if (newtop > limit || newtop > AMASK) begin
      r.status = ST_ARENA;
      return r;
    end
    blk_start[s] = 20'(heap_top);
    blk_size[s] = 20'(need);
    blk_free[s] = 0;
    blk_link[s] = '0;
    blk_used[s] = 1;
    if (head >= NONE) head = s;
    else blk_link[tail] = 6'(s);
    tail = s;
    r.data_address = 20'((heap_top + hdr) & AMASK);
    heap_top = newtop;
    r.heap_grew = 1'b1;
    return r;
  endfunction

  function automatic out_item_t predict_release(logic [19:0] addr);
    out_item_t r;
    int cur, nx, hit, merges;
    r = '0;
    hit = NONE;
    merges = 0;
    cur = head;
    for (int n = 0; cur < NONE && n < NB; n++) begin
      if (!blk_free[cur] && ((longint'(blk_start[cur]) + hdr) & AMASK) == addr) begin
        hit = cur;
        break;
      end
      cur = link_of(cur);
    end
    if (hit >= NONE) begin
      r.status = ST_BADREL;
      return r;
    end
    blk_free[hit] = 1;
    // One pass; a merged block is not tested again against its new neighbor.
    cur = head;
    for (int n = 0; cur < NONE && n < NB; n++) begin
      nx = link_of(cur);
      if (blk_free[cur] && nx < NONE && blk_free[nx]) begin
        blk_size[cur] = 20'((longint'(blk_size[cur]) + blk_size[nx] + hdr) & AMASK);
        if (nx == tail) tail = cur;
        else blk_link[cur] = blk_link[nx];
        blk_used[nx] = 0;
        if (merges < 63) merges++;
      end
      cur = link_of(cur);
    end
    nf_pos = NONE;
    r.merge_count = 6'(merges);
    return r;
  endfunction

  // Data address of a random block in use, or a random address when none is.
  function automatic logic [19:0] live_address();
    int ids[$];
    int cur;
    cur = head;
    for (int n = 0; cur < NONE && n < NB; n++) begin
      if (!blk_free[cur]) ids.push_back(cur);
      cur = link_of(cur);
    end
    if (ids.size() == 0) return 20'($urandom_range(0, 20'hFFFFF));
    cur = ids[$urandom_range(0, ids.size() - 1)];
    return 20'((longint'(blk_start[cur]) + hdr) & AMASK);
  endfunction

  task automatic queue_req(logic op, logic [19:0] size, logic [19:0] addr);
    in_item_t it;
    it.op = op;
    it.request_size = size;
    it.release_address = addr;
    pending_reqs.push_back(it);
    expected_results.push_back(op == OP_FREE ? predict_release(addr) : predict_alloc(size));
  endtask

  task automatic queue_random(int count, int alloc_pct);
    logic [19:0] sz, ad;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70) sz = 20'($urandom_range(1, 256));
      else if (r < 90) sz = 20'($urandom_range(1, 4096));
      else if (r < 95) sz = 20'($urandom_range(0, 20'hFFFFF));
      else sz = 0;
      r = $urandom_range(0, 99);
      if (r < 80) ad = live_address();
      else if (r < 90) ad = 20'(live_address() + 4 * $urandom_range(1, 3));
      else ad = 20'($urandom_range(0, 20'hFFFFF));
      if ($urandom_range(0, 99) < alloc_pct) queue_req(OP_ALLOC, sz, ad);
      else queue_req(OP_FREE, sz, ad);
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POLICY) policy = policy_t'(val[1:0]);
    else if (idx == REG_LIMIT) limit = longint'(val);
    else if (idx == REG_HDR) hdr = longint'(val[6:0]);
  endtask

  task automatic setup(policy_t pol, logic [19:0] lim, logic [6:0] h, int mode);
    wait_idle();
    write_reg(REG_POLICY, 20'(pol));
    write_reg(REG_LIMIT, lim);
    write_reg(REG_HDR, 20'(h));
    idle_mode = mode;
  endtask

  // Sender: acceptance is seen at the rising edge, the next item is driven at the falling one.
  logic in_taken = 1'b0;
  always @(posedge clk) in_taken <= in_valid && in_ready;

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_reqs.size() != 0 &&
          !(idle_mode == 0 && $urandom_range(0, 99) < 35) &&
          !(idle_mode == 1 && $urandom_range(0, 99) < 64)) begin
        in_valid <= 1'b1;
        in_item <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver, with a long hold-off on request so that the block backs up.
  int hold_left = 0;
  int holds_done = 0;
  always @(negedge clk) begin
    if (holds_done < hold_asks) begin
      holds_done <= holds_done + 1;
      hold_left <= 500;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (idle_mode == 0) begin
      out_ready <= $urandom_range(0, 99) >= 64;
    end else if (idle_mode == 1) begin
      out_ready <= $urandom_range(0, 99) >= 35;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: %p", out_item);
        fails++;
      end else begin
        e = expected_results.pop_front();
        if (out_item.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_item.status);
          fails++;
        end
        if (out_item.data_address !== e.data_address) begin
          $error("data_address: expected %0h, got %0h", e.data_address, out_item.data_address);
          fails++;
        end
        if (out_item.was_reused !== e.was_reused) begin
          $error("was_reused: expected %0b, got %0b", e.was_reused, out_item.was_reused);
          fails++;
        end
        if (out_item.was_split !== e.was_split) begin
          $error("was_split: expected %0b, got %0b", e.was_split, out_item.was_split);
          fails++;
        end
        if (out_item.heap_grew !== e.heap_grew) begin
          $error("heap_grew: expected %0b, got %0b", e.heap_grew, out_item.heap_grew);
          fails++;
        end
        if (out_item.merge_count !== e.merge_count) begin
          $error("merge_count: expected %0d, got %0d", e.merge_count, out_item.merge_count);
          fails++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("heap_block_allocator_unit_tb: FAIL");
    $finish;
  end

  initial begin
    logic [19:0] a;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    idle_mode = 2;

    // Directed: defaults after reset, then every register at its extremes.
    queue_req(OP_ALLOC, 20'd0, 20'hFFFFF);
    queue_req(OP_FREE, 20'hFFFFF, 20'd0);
    queue_req(OP_ALLOC, 20'd1, 20'd0);
    queue_req(OP_ALLOC, 20'd200, 20'd0);
    queue_req(OP_ALLOC, 20'd8, 20'd0);
    queue_req(OP_ALLOC, 20'hFFFFF, 20'd0);
    a = live_address();
    queue_req(OP_FREE, 20'd0, a);
    queue_req(OP_FREE, 20'd0, a);
    queue_req(OP_FREE, 20'd0, 20'hFFFFF);
    queue_req(OP_ALLOC, 20'd4, 20'd0);
    queue_req(OP_FREE, 20'd0, live_address());
    queue_req(OP_FREE, 20'd0, live_address());
    queue_req(OP_FREE, 20'd0, live_address());
    queue_req(OP_ALLOC, 20'd100, 20'd0);

    setup(POL_NEXT, 20'd0, 7'd127, 2);
    queue_req(OP_ALLOC, 20'd16, 20'd0);
    queue_req(OP_ALLOC, 20'd600, 20'd0);
    queue_req(OP_ALLOC, 20'd16, 20'd0);
    queue_req(OP_ALLOC, 20'd3, 20'd0);
    queue_req(OP_FREE, 20'd0, live_address());
    setup(POL_FIRST, 20'hFFFFF, 7'd0, 2);
    queue_req(OP_ALLOC, 20'd12, 20'd0);
    queue_req(OP_FREE, 20'd0, live_address());

    // Random phases: varying policy, header and limit; alloc-heavy runs fill the table.
    setup(POL_BEST, 20'hFFFFF, 7'd24, 0);
    queue_random(250, 60);
    setup(POL_WORST, 20'hFFFFF, 7'd0, 1);
    queue_random(250, 75);
    setup(POL_NEXT, 20'hFFFFF, 7'd64, 2);
    queue_random(100, 55);
    hold_asks = hold_asks + 1;
    queue_random(150, 55);
    setup(POL_FIRST, 20'(heap_top + 3000), 7'd127, 2);
    queue_random(150, 60);
    setup(POL_NEXT, 20'd0, 7'd8, 0);
    queue_random(100, 70);
    wait_idle();

    if (fails == 0) $display("heap_block_allocator_unit_tb: PASS");
    else $display("heap_block_allocator_unit_tb: FAIL");
    $finish;
  end
endmodule
